// ===== hdl/nrs_pkg.sv =====
package nrs_pkg;

	localparam int COORD_BITS_DEF = 12;

	localparam int DIM_BITS   = 13;
	localparam int SEED_BITS  = 32;
	localparam int FREQ_BITS  = 16;
	localparam int TALL_BITS  = 17;
	localparam int COLOR_BITS = 24;
	localparam int CH_BITS    = 8;
	localparam int IDX_BITS   = 3;
	localparam int DATA_BITS  = 32;

	localparam logic [IDX_BITS-1:0] REG_IMAGE_WIDTH     = 3'd0;
	localparam logic [IDX_BITS-1:0] REG_IMAGE_HEIGHT    = 3'd1;
	localparam logic [IDX_BITS-1:0] REG_NOISE_SEED      = 3'd2;
	localparam logic [IDX_BITS-1:0] REG_RIDGE_FREQUENCY = 3'd3;
	localparam logic [IDX_BITS-1:0] REG_RIDGE_HEIGHT    = 3'd4;
	localparam logic [IDX_BITS-1:0] REG_BASE_COLOR      = 3'd5;

	localparam logic [DIM_BITS-1:0]   RST_WIDTH  = 13'd512;
	localparam logic [DIM_BITS-1:0]   RST_HEIGHT = 13'd256;
	localparam logic [SEED_BITS-1:0]  RST_SEED   = 32'd11;
	localparam logic [FREQ_BITS-1:0]  RST_FREQ   = 16'd2048;
	localparam logic [TALL_BITS-1:0]  RST_TALL   = 17'd49152;
	localparam logic [COLOR_BITS-1:0] RST_COLOR  = 24'h786E82;

	localparam logic [31:0] K_HASH_X = 32'd374761393;
	localparam logic [31:0] K_HASH_S = 32'd668265263;
	localparam logic [31:0] K_HASH_M = 32'd1274126177;

	localparam logic [17:0] Q_OCT2   = 18'd150733;
	localparam logic [18:0] Q_OCT3   = 19'd334234;
	localparam logic [15:0] Q_W1     = 16'd39322;
	localparam logic [15:0] Q_W2     = 16'd19661;
	localparam logic [15:0] Q_W3     = 16'd6554;
	localparam logic [15:0] Q_BASE_H = 16'd29491;
	localparam logic [15:0] Q_SPAN_H = 16'd36045;
	localparam logic [15:0] Q_BASE_C = 16'd42598;
	localparam logic [15:0] Q_SPAN_C = 16'd22938;
	localparam logic [7:0]  A_BASE   = 8'd150;
	localparam logic [6:0]  A_SPAN   = 7'd105;

	localparam logic [31:0] SEED_OFS2 = 32'd7;
	localparam logic [31:0] SEED_OFS3 = 32'd19;

	localparam int VF_BITS = 16;

	typedef logic [31:0] word_t;

endpackage

// ===== hdl/noise_ridgeline_silhouette_shader.sv =====
// Ridgeline silhouette shader, one pixel per clock while the output is not stalled.
// Input channel: column and row with in_valid / in_stall. A transfer takes place
// on a rising edge with in_valid high and in_stall low.
// Output channel: covered, red, green, blue, alpha and ridge_row with
// out_valid / out_stall, same transfer rule.
// Configuration: wr_en, wr_index and wr_data write one register per edge;
// write only while no pixel is in flight.
// Throughput: one pixel per clock, sustained while out_stall holds no waiting result.
// Most of the pipeline from input transfer to out_valid is made up of the
// two restoring dividers, one quotient bit per stage: column scaling
// (COORD_BITS + 24 stages) and depth fraction (16 stages).
// Reset clears all stage valid bits and loads the register defaults.
// When out_stall holds a waiting result, the whole pipe freezes and in_stall
// rises in the same cycle; nothing is dropped or repeated.
module noise_ridgeline_silhouette_shader #(
	parameter int COORD_BITS = nrs_pkg::COORD_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              wr_en,
	input  logic [nrs_pkg::IDX_BITS-1:0]      wr_index,
	input  logic [nrs_pkg::DATA_BITS-1:0]     wr_data,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic [COORD_BITS-1:0]             column,
	input  logic [COORD_BITS-1:0]             row,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic                              covered,
	output logic [nrs_pkg::CH_BITS-1:0]       red,
	output logic [nrs_pkg::CH_BITS-1:0]       green,
	output logic [nrs_pkg::CH_BITS-1:0]       blue,
	output logic [nrs_pkg::CH_BITS-1:0]       alpha,
	output logic [nrs_pkg::DIM_BITS-1:0]      ridge_row
);
	import nrs_pkg::*;

	localparam int PRODW = COORD_BITS + FREQ_BITS;
	localparam int NUMW  = PRODW + 8;
	localparam int POSW  = NUMW + 4;
	localparam int CMPW  = (COORD_BITS > DIM_BITS ? COORD_BITS : DIM_BITS) + 1;
	localparam int LAT   = NUMW + 31;

	// configuration
	logic [DIM_BITS-1:0]   width_q, height_q;
	logic [SEED_BITS-1:0]  seed_q;
	logic [FREQ_BITS-1:0]  freq_q;
	logic [TALL_BITS-1:0]  tall_q;
	logic [COLOR_BITS-1:0] color_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= RST_WIDTH;
			height_q <= RST_HEIGHT;
			seed_q   <= RST_SEED;
			freq_q   <= RST_FREQ;
			tall_q   <= RST_TALL;
			color_q  <= RST_COLOR;
		end else if (wr_en) begin
			case (wr_index)
				REG_IMAGE_WIDTH:     width_q  <= wr_data[DIM_BITS-1:0];
				REG_IMAGE_HEIGHT:    height_q <= wr_data[DIM_BITS-1:0];
				REG_NOISE_SEED:      seed_q   <= wr_data[SEED_BITS-1:0];
				REG_RIDGE_FREQUENCY: freq_q   <= wr_data[FREQ_BITS-1:0];
				REG_RIDGE_HEIGHT:    tall_q   <= wr_data[TALL_BITS-1:0];
				REG_BASE_COLOR:      color_q  <= wr_data[COLOR_BITS-1:0];
				default: ;
			endcase
		end
	end

	logic [DIM_BITS-1:0]  wdiv;
	logic [TALL_BITS-1:0] tall_sat;
	word_t                oct_seed [3];
	assign wdiv        = (width_q == '0) ? DIM_BITS'(1) : width_q;
	assign tall_sat    = (tall_q > TALL_BITS'(65536)) ? TALL_BITS'(65536) : tall_q;
	assign oct_seed[0] = seed_q;
	assign oct_seed[1] = seed_q + SEED_OFS2;
	assign oct_seed[2] = seed_q + SEED_OFS3;

	// valid bits and global advance
	logic [LAT-1:0] vld_sx;
	logic           en;
	assign en       = !(vld_sx[LAT-1] && out_stall);
	assign in_stall = !en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_sx <= '0;
		end else if (en) begin
			vld_sx <= {vld_sx[LAT-2:0], in_valid};
		end
	end

	// s1, s2: capture, column * frequency
	logic [COORD_BITS-1:0] col_s1, row_s1, row_s2;
	logic [PRODW-1:0]      prod_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			col_s1  <= column;
			row_s1  <= row;
			prod_s2 <= PRODW'(col_s1) * PRODW'(freq_q);
			row_s2  <= row_s1;
		end
	end

	// s3: fx = prod * 256 / width, one quotient bit per stage
	logic [NUMW-1:0]       fxd_num_s3 [NUMW+1];
	logic [DIM_BITS-1:0]   fxd_rem_s3 [NUMW+1];
	logic [COORD_BITS-1:0] fxd_row_s3 [NUMW+1];

	assign fxd_num_s3[0] = {prod_s2, 8'd0};
	assign fxd_rem_s3[0] = '0;
	assign fxd_row_s3[0] = row_s2;

	for (genvar k = 1; k <= NUMW; k++) begin : g_fxd
		logic [DIM_BITS:0] t;
		logic              ge;
		assign t  = {fxd_rem_s3[k-1], fxd_num_s3[k-1][NUMW-1]};
		assign ge = t >= {1'b0, wdiv};
		always_ff @(posedge clk) begin
			if (en) begin
				fxd_num_s3[k] <= {fxd_num_s3[k-1][NUMW-2:0], ge};
				fxd_rem_s3[k] <= ge ? DIM_BITS'(t - {1'b0, wdiv}) : t[DIM_BITS-1:0];
				fxd_row_s3[k] <= fxd_row_s3[k-1];
			end
		end
	end

	// s4: octave position partial products
	logic [NUMW-1:0]       fx_s4;
	logic [35:0]           p2lo_s4;
	logic [36:0]           p3lo_s4;
	logic [NUMW-1:0]       p2hi_s4;
	logic [NUMW:0]         p3hi_s4;
	logic [COORD_BITS-1:0] row_s4;
	logic [NUMW-1:0]       fxq;
	assign fxq = fxd_num_s3[NUMW];

	always_ff @(posedge clk) begin
		if (en) begin
			fx_s4   <= fxq;
			p2lo_s4 <= 36'(fxq[17:0]) * 36'(Q_OCT2);
			p3lo_s4 <= 37'(fxq[17:0]) * 37'(Q_OCT3);
			p2hi_s4 <= NUMW'(fxq[NUMW-1:18]) * NUMW'(Q_OCT2);
			p3hi_s4 <= (NUMW+1)'(fxq[NUMW-1:18]) * (NUMW+1)'(Q_OCT3);
			row_s4  <= fxd_row_s3[NUMW];
		end
	end

	// s5: positions
	logic [POSW-1:0]       pos_s5 [3];
	logic [COORD_BITS-1:0] row_s5;
	logic [NUMW+19:0]      sum2, sum3;
	assign sum2 = ((NUMW+20)'(p2hi_s4) << 18) + (NUMW+20)'(p2lo_s4);
	assign sum3 = ((NUMW+20)'(p3hi_s4) << 18) + (NUMW+20)'(p3lo_s4);

	always_ff @(posedge clk) begin
		if (en) begin
			pos_s5[0] <= POSW'(fx_s4);
			pos_s5[1] <= sum2[POSW+15:16];
			pos_s5[2] <= sum3[POSW+15:16];
			row_s5    <= row_s4;
		end
	end

	// s6..s9: lattice hash and smoothstep blend per octave
	word_t        ixk_s6 [3], sk_s6 [3];
	logic [15:0]  fr_s6 [3], f2_s6 [3];
	word_t        xa_s7 [3], xb_s7 [3];
	logic [16:0]  sm_s7 [3], sm_s8 [3];
	word_t        ma_s8 [3], mb_s8 [3];
	logic [15:0]  oct_s9 [3];
	logic [COORD_BITS-1:0] row_s6, row_s7, row_s8, row_s9;

	for (genvar o = 0; o < 3; o++) begin : g_oct
		word_t       ha, hb;
		logic [33:0] sp;
		logic [15:0] av, bv;
		logic [33:0] mix;
		logic [31:0] ff;
		assign ff  = 32'(pos_s5[o][15:0]) * 32'(pos_s5[o][15:0]);
		assign ha  = ixk_s6[o] + sk_s6[o];
		assign hb  = ha + K_HASH_X;
		assign sp  = 34'(f2_s6[o]) * (34'(196608) - 34'({fr_s6[o], 1'b0}));
		assign av  = ma_s8[o][15:0] ^ ma_s8[o][31:16];
		assign bv  = mb_s8[o][15:0] ^ mb_s8[o][31:16];
		assign mix = 34'(av) * (34'(65536) - 34'(sm_s8[o])) + 34'(bv) * 34'(sm_s8[o]);
		always_ff @(posedge clk) begin
			if (en) begin
				ixk_s6[o] <= word_t'(pos_s5[o][POSW-1:16]) * K_HASH_X;
				sk_s6[o]  <= oct_seed[o] * K_HASH_S;
				fr_s6[o]  <= pos_s5[o][15:0];
				f2_s6[o]  <= ff[31:16];
				xa_s7[o]  <= ha ^ (ha >> 13);
				xb_s7[o]  <= hb ^ (hb >> 13);
				sm_s7[o]  <= sp[32:16];
				ma_s8[o]  <= xa_s7[o] * K_HASH_M;
				mb_s8[o]  <= xb_s7[o] * K_HASH_M;
				sm_s8[o]  <= sm_s7[o];
				oct_s9[o] <= mix[31:16];
			end
		end
	end

	// s10..s13: weighted sum, ridge height, ridge row
	logic [15:0]           nz_s10, inner_s11, p_s12;
	logic [DIM_BITS-1:0]   top_s13;
	logic [COORD_BITS-1:0] row_s10, row_s11, row_s12, row_s13;
	logic [33:0]           wsum;
	logic [31:0]           hspan;
	logic [32:0]           pprod;
	logic [29:0]           tprod;
	assign wsum  = 34'(oct_s9[0]) * 34'(Q_W1) + 34'(oct_s9[1]) * 34'(Q_W2)
	             + 34'(oct_s9[2]) * 34'(Q_W3);
	assign hspan = 32'(Q_SPAN_H) * 32'(nz_s10);
	assign pprod = 33'(tall_sat) * 33'(inner_s11);
	assign tprod = (30'(65536) - 30'(p_s12)) * 30'(height_q);

	always_ff @(posedge clk) begin
		if (en) begin
			row_s6    <= row_s5;
			row_s7    <= row_s6;
			row_s8    <= row_s7;
			row_s9    <= row_s8;
			nz_s10    <= wsum[31:16];
			row_s10   <= row_s9;
			inner_s11 <= Q_BASE_H + hspan[31:16];
			row_s11   <= row_s10;
			p_s12     <= pprod[31:16];
			row_s12   <= row_s11;
			top_s13   <= tprod[28:16];
			row_s13   <= row_s12;
		end
	end

	// s14: coverage test, divider operands
	logic                cov_s14;
	logic [DIM_BITS-1:0] top_s14, diff_s14;
	logic [DIM_BITS:0]   den_s14;
	logic                cov_c;
	assign cov_c = (CMPW'(row_s13) >= CMPW'(top_s13)) && (CMPW'(row_s13) < CMPW'(height_q));

	always_ff @(posedge clk) begin
		if (en) begin
			cov_s14  <= cov_c;
			top_s14  <= top_s13;
			diff_s14 <= cov_c ? DIM_BITS'(CMPW'(row_s13) - CMPW'(top_s13)) : '0;
			den_s14  <= (DIM_BITS+1)'(height_q) - (DIM_BITS+1)'(top_s13) + (DIM_BITS+1)'(1);
		end
	end

	// s15: vf = diff * 2^16 / den; diff < den so only 16 quotient bits
	logic [VF_BITS-1:0]  vfd_q_s15   [VF_BITS+1];
	logic [DIM_BITS:0]   vfd_rem_s15 [VF_BITS+1];
	logic [DIM_BITS:0]   vfd_den_s15 [VF_BITS+1];
	logic                vfd_cov_s15 [VF_BITS+1];
	logic [DIM_BITS-1:0] vfd_top_s15 [VF_BITS+1];

	assign vfd_q_s15[0]   = '0;
	assign vfd_rem_s15[0] = {1'b0, diff_s14};
	assign vfd_den_s15[0] = den_s14;
	assign vfd_cov_s15[0] = cov_s14;
	assign vfd_top_s15[0] = top_s14;

	for (genvar k = 1; k <= VF_BITS; k++) begin : g_vfd
		logic [DIM_BITS+1:0] t;
		logic                ge;
		assign t  = {vfd_rem_s15[k-1], 1'b0};
		assign ge = t >= {1'b0, vfd_den_s15[k-1]};
		always_ff @(posedge clk) begin
			if (en) begin
				vfd_q_s15[k]   <= {vfd_q_s15[k-1][VF_BITS-2:0], ge};
				vfd_rem_s15[k] <= ge ? (DIM_BITS+1)'(t - {1'b0, vfd_den_s15[k-1]})
				                     : t[DIM_BITS:0];
				vfd_den_s15[k] <= vfd_den_s15[k-1];
				vfd_cov_s15[k] <= vfd_cov_s15[k-1];
				vfd_top_s15[k] <= vfd_top_s15[k-1];
			end
		end
	end

	// s16: shading scale and alpha
	logic [15:0]         scale_s16;
	logic [7:0]          alpha_s16;
	logic                cov_s16;
	logic [DIM_BITS-1:0] top_s16;
	logic [30:0]         cspan;
	logic [22:0]         aspan;
	assign cspan = 31'(Q_SPAN_C) * 31'(vfd_q_s15[VF_BITS]);
	assign aspan = 23'(A_SPAN) * 23'(vfd_q_s15[VF_BITS]);

	always_ff @(posedge clk) begin
		if (en) begin
			scale_s16 <= Q_BASE_C + 16'(cspan[30:16]);
			alpha_s16 <= A_BASE + 8'(aspan[22:16]);
			cov_s16   <= vfd_cov_s15[VF_BITS];
			top_s16   <= vfd_top_s15[VF_BITS];
		end
	end

	// s17: output register
	logic [23:0] rp, gp, bp;
	assign rp = 24'(color_q[23:16]) * 24'(scale_s16);
	assign gp = 24'(color_q[15:8]) * 24'(scale_s16);
	assign bp = 24'(color_q[7:0]) * 24'(scale_s16);

	always_ff @(posedge clk) begin
		if (en) begin
			covered   <= cov_s16;
			red       <= cov_s16 ? rp[23:16] : '0;
			green     <= cov_s16 ? gp[23:16] : '0;
			blue      <= cov_s16 ? bp[23:16] : '0;
			alpha     <= cov_s16 ? alpha_s16 : '0;
			ridge_row <= top_s16;
		end
	end

	assign out_valid = vld_sx[LAT-1];

endmodule

// ===== hdl/nrs_checker.sv =====
module nrs_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_stall,
	input logic       out_valid,
	input logic       out_stall,
	input logic       covered,
	input logic [7:0] red,
	input logic [7:0] green,
	input logic [7:0] blue,
	input logic [7:0] alpha
);
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(alpha) && $stable(covered))
		else $error("stalled result changed");

	a_bp: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall == (out_valid && out_stall))
		else $error("input stall does not follow output backpressure");

	a_clear: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !covered |-> red == 8'd0 && green == 8'd0 && blue == 8'd0
			&& alpha == 8'd0)
		else $error("uncovered pixel carries color");

	a_alpha: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && covered |-> alpha >= 8'd150 && alpha != 8'd255)
		else $error("covered alpha out of range");
endmodule

bind noise_ridgeline_silhouette_shader nrs_checker u_nrs_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_stall  (in_stall),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.covered   (covered),
	.red       (red),
	.green     (green),
	.blue      (blue),
	.alpha     (alpha)
);
